[rtl/sbsh_pkg.sv]
`timescale 1ns / 1ps

package sbsh_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [7:0][31:0] t_hash;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] rnd;
    } t_rnd_ctl;

    localparam t_hash HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word big_s0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_s1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_s0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_s1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

endpackage

[rtl/sbsh_round.sv]
`timescale 1ns / 1ps

module sbsh_round (
    input  logic               i_clk,
    input  sbsh_pkg::t_rnd_ctl i_ctl,
    input  sbsh_pkg::t_hash    i_h,
    input  sbsh_pkg::t_word    i_w,
    output sbsh_pkg::t_hash    o_v
);
    import sbsh_pkg::*;

    t_hash r_v;
    t_hash n_v;
    t_word t1;
    t_word t2;

    always_comb begin
        t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + round_k(i_ctl.rnd) + i_w;
        t2 = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = t1 + t2;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_h;
        end else if (i_ctl.step) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;

endmodule

[rtl/sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps

// SHA-256 over a byte stream, one byte per absorb item. An absorb item that
// fills a 64-byte block stalls the input while the block is compressed one
// round per cycle (load, 64 rounds, hash update). A finish item pads one byte
// per cycle through the block shift register up to the end of the block
// (64 - n pad bytes for n pending bytes), then compresses; with 56 or more
// bytes pending a second block of 64 pad bytes and a second compression
// follow. The eight digest words then leave word 0 first, one per cycle
// unless the output is stalled, and the next item is taken once the last
// word is registered.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sbsh_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,
        S_LOAD = 6'b000100,
        S_COMP = 6'b001000,
        S_ADD  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_cnt, n_cnt;
    logic [63:0]  r_len, n_len;
    logic         r_mark, n_mark;
    logic         r_lenok, n_lenok;
    logic         r_fin, n_fin;
    logic [5:0]   r_rnd, n_rnd;
    logic [2:0]   r_idx, n_idx;
    t_hash        r_h, n_h;
    logic [511:0] r_blk, n_blk;
    logic         r_ovalid, n_ovalid;
    logic [31:0]  r_oword, n_oword;
    logic [2:0]   r_oidx, n_oidx;
    logic         r_olast, n_olast;

    t_rnd_ctl     rnd_ctl;
    t_hash        vars;
    t_word        w_new;
    logic         len_slot;
    logic [7:0]   pad_byte;

    sbsh_round u_round (
        .i_clk (i_clk),
        .i_ctl (rnd_ctl),
        .i_h   (r_h),
        .i_w   (r_blk[511:480]),
        .o_v   (vars)
    );

    always_comb begin
        w_new = r_blk[511:480] + small_s0(r_blk[479:448]) + r_blk[223:192]
                + small_s1(r_blk[63:32]);
        len_slot = r_lenok && (r_fill >= 6'd56);
        pad_byte = r_mark ? 8'h80 : (len_slot ? r_len[63:56] : 8'h00);

        n_state  = r_state;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_mark   = r_mark;
        n_lenok  = r_lenok;
        n_fin    = r_fin;
        n_rnd    = r_rnd;
        n_idx    = r_idx;
        n_h      = r_h;
        n_blk    = r_blk;
        n_ovalid = r_ovalid;
        n_oword  = r_oword;
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        rnd_ctl      = '0;
        rnd_ctl.rnd  = r_rnd;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_command) begin
                        n_blk  = {r_blk[503:0], i_data_byte};
                        n_fill = r_fill + 6'd1;
                        n_cnt  = r_cnt + 61'd1;
                        n_fin  = 1'b0;
                        if (r_fill == 6'd63) begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_len   = {r_cnt, 3'b000};
                        n_cnt   = '0;
                        n_mark  = 1'b1;
                        n_lenok = (r_fill < 6'd56);
                        n_fin   = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_blk  = {r_blk[503:0], pad_byte};
                n_mark = 1'b0;
                if (len_slot) begin
                    n_len = {r_len[55:0], 8'h00};
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                rnd_ctl.load = 1'b1;
                n_rnd   = '0;
                n_state = S_COMP;
            end
            S_COMP: begin
                rnd_ctl.step = 1'b1;
                n_blk = {r_blk[479:0], w_new};
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + vars[i];
                end
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_lenok) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_lenok = 1'b1;
                    n_state = S_PAD;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_h[r_idx];
                    n_oidx   = r_idx;
                    n_olast  = (r_idx == 3'd7);
                    n_idx    = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_h     = HASH_IV;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_mark   <= 1'b0;
            r_lenok  <= 1'b0;
            r_fin    <= 1'b0;
            r_rnd    <= '0;
            r_idx    <= '0;
            r_h      <= HASH_IV;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
            r_mark   <= n_mark;
            r_lenok  <= n_lenok;
            r_fin    <= n_fin;
            r_rnd    <= n_rnd;
            r_idx    <= n_idx;
            r_h      <= n_h;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_blk   <= n_blk;
        r_oword <= n_oword;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_olast;

endmodule
